// File: hdl/sds_pkg.sv
// Shared types and constants for the SCAN disk scheduler.
`timescale 1ns / 1ps

package sds_pkg;

  localparam int CYL_W     = 16;  // cylinder field width
  localparam int DC_W      = 17;  // disk_cylinders register width
  localparam int SEEK_W    = 18;  // total seek width
  localparam int CFG_IDX_W = 4;   // configuration index width
  localparam int CFG_DAT_W = 17;  // widest register

  localparam logic [CFG_IDX_W-1:0] REG_DISK_CYL   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_START = CFG_IDX_W'(1);

  localparam logic KIND_MOVE  = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  // What every cell of the row does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,  // sorted insert of the broadcast value
    CELL_SHIFT,   // take right neighbour (pop cell 0)
    CELL_ROTATE   // shift, top cell takes cell 0
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     valid;   // cell holds an entry
    logic     is_top;  // highest valid cell
  } cell_ctrl_t;

endpackage

// File: hdl/sds_req_if.sv
// Request channel: one cylinder request per transfer.
`timescale 1ns / 1ps

interface sds_req_if import sds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CYL_W-1:0] cylinder;
  logic             batch_end;

  modport source (output valid, output cylinder, output batch_end, input ready);
  modport sink   (input valid, input cylinder, input batch_end, output ready);
endinterface

// File: hdl/sds_rec_if.sv
// Result channel: move records and the closing total record.
`timescale 1ns / 1ps

interface sds_rec_if import sds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              record_kind;
  logic [CYL_W-1:0]  from_cyl;
  logic [CYL_W-1:0]  to_cyl;
  logic [CYL_W-1:0]  distance;
  logic [SEEK_W-1:0] total_seek;
  logic              overflowed;
  logic              final_record;

  modport source (output valid, output record_kind, output from_cyl, output to_cyl,
                  output distance, output total_seek, output overflowed,
                  output final_record, input ready);
  modport sink   (input valid, input record_kind, input from_cyl, input to_cyl,
                  input distance, input total_seek, input overflowed,
                  input final_record, output ready);
endinterface

// File: hdl/sds_cell.sv
// One cell of the sorted row: holds a single cylinder entry.
`timescale 1ns / 1ps

module sds_cell import sds_pkg::*; #(
  parameter int CW = 16
) (
  input  logic          clk,
  input  cell_ctrl_t    ctrl,
  input  logic [CW-1:0] din,
  input  logic [CW-1:0] left_val,
  input  logic          left_gt,
  input  logic [CW-1:0] right_val,
  input  logic [CW-1:0] wrap_val,
  output logic [CW-1:0] val,
  output logic          gt
);

  logic [CW-1:0] val_r;
  logic [CW-1:0] val_nxt;

  // empty cells count as greater so the new value lands at the first free slot
  assign gt  = !ctrl.valid || (val_r > din);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (gt) begin
          val_nxt = left_gt ? left_val : din;
        end
      end
      CELL_SHIFT:  val_nxt = right_val;
      CELL_ROTATE: val_nxt = ctrl.is_top ? wrap_val : right_val;
      default:     val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: hdl/sds_row.sv
// Row of sorted cells with bottom and top read taps.
`timescale 1ns / 1ps

module sds_row import sds_pkg::*; #(
  parameter int N    = 16,
  parameter int CW   = 16,
  parameter int CNTW = 5,
  parameter int IDXW = 4
) (
  input  logic            clk,
  input  cell_op_t        op,
  input  logic [CW-1:0]   din,
  input  logic [CNTW-1:0] count,
  output logic [CW-1:0]   bot_val,
  output logic [CW-1:0]   top_val
);

  logic [CW-1:0] vals [N];
  logic          gts  [N];
  logic [IDXW-1:0] top_idx;

  for (genvar i = 0; i < N; i++) begin : g_cell
    cell_ctrl_t    ctrl;
    logic [CW-1:0] lv;
    logic          lg;
    logic [CW-1:0] rv;

    assign ctrl.op     = op;
    assign ctrl.valid  = CNTW'(i) < count;
    assign ctrl.is_top = CNTW'(i + 1) == count;

    if (i == 0) begin : g_first
      assign lv = din;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign lg = gts[i-1];
    end

    if (i == N - 1) begin : g_last
      assign rv = vals[i];
    end else begin : g_inner
      assign rv = vals[i+1];
    end

    sds_cell #(.CW(CW)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .din       (din),
      .left_val  (lv),
      .left_gt   (lg),
      .right_val (rv),
      .wrap_val  (vals[0]),
      .val       (vals[i]),
      .gt        (gts[i])
    );
  end

  assign top_idx = IDXW'(count - CNTW'(1));
  assign bot_val = vals[0];
  assign top_val = vals[top_idx];

endmodule

// File: hdl/scan_disk_schedule_unit.sv
// SCAN (elevator) disk scheduler: sorted request row and sweep sequencer.
//
// Use: requests arrive on in_req (valid/ready), one cylinder per request;
// the request flagged batch_end closes the batch. Requests are kept in a
// row of sorted cells; one is taken every cycle while loading. Requests
// above the last cylinder are clamped; past MAX_REQUESTS they are dropped
// and flagged on every record of the batch.
// After batch_end the block sweeps up from the head, visits the last
// cylinder, jumps back and sweeps down, giving one move record per cycle
// on out_rec while out_rec is not stalled, then one total record with the
// seek sum and final_record. Before the sweep the cell row rotates each
// request below the head to the back. No record is given while leaving
// the skip, the upward sweep or the downward sweep, nor in the
// last-cylinder state when the upward sweep already ends on the last
// cylinder.
// No new request is taken until the total record is in the output register.
// A stalled receiver freezes the sweep; the output register keeps its
// record. Reset empties the batch and sets disk_cylinders to 200 and
// head_start to 0; configuration (cfg_we/cfg_index/cfg_data) must be written
// only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module scan_disk_schedule_unit import sds_pkg::*; #(
  parameter int MAX_REQUESTS = 16,
  parameter int CYL_BITS     = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sds_req_if.sink              in_req,
  sds_rec_if.source            out_rec,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // cell width: cylinder values never exceed 2^CYL_BITS - 1
  localparam int CW   = (CYL_BITS < CYL_W) ? CYL_BITS : CYL_W;
  localparam int CNTW = $clog2(MAX_REQUESTS + 1);
  localparam int IDXW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam logic [DC_W-1:0] CYL_MAX_L = DC_W'((64'd1 << CW) - 64'd1);
  localparam logic [CNTW-1:0] CNT_FULL  = CNTW'(MAX_REQUESTS);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_SKIP  = 3'd1;  // rotate lower entries to the back
  localparam logic [2:0] ST_UP    = 3'd2;
  localparam logic [2:0] ST_LAST  = 3'd3;
  localparam logic [2:0] ST_DOWN  = 3'd4;
  localparam logic [2:0] ST_TOTAL = 3'd5;

  // configuration
  logic [DC_W-1:0]  disk_cyl_r;
  logic [CYL_W-1:0] head_start_r;

  // control
  logic [2:0]        state_r, state_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic [CNTW-1:0]   lo_r, lo_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [SEEK_W-1:0] seek_r, seek_nxt;
  logic              drop_r, drop_nxt;

  // output register
  logic              out_valid_r;
  logic              out_kind_r;
  logic [CYL_W-1:0]  out_from_r;
  logic [CYL_W-1:0]  out_to_r;
  logic [CYL_W-1:0]  out_dist_r;
  logic [SEEK_W-1:0] out_total_r;
  logic              out_ovf_r;
  logic              out_final_r;

  logic [DC_W-1:0] last_raw, last_l;
  logic [CW-1:0]   last_c, head_c, req_c;
  logic [CW-1:0]   bot_val, top_val, bot_c, top_c;
  cell_op_t        row_op;
  logic            in_acc, can_load;
  logic            emit, emit_total;
  logic [CW-1:0]   em_from, em_to, em_dist;
  logic [SEEK_W:0] seek_sum;

  // last cylinder, saturated at the cylinder range
  assign last_raw = (disk_cyl_r == '0) ? '0 : disk_cyl_r - DC_W'(1);
  assign last_l   = (last_raw > CYL_MAX_L) ? CYL_MAX_L : last_raw;
  assign last_c   = last_l[CW-1:0];

  assign req_c  = ({1'b0, in_req.cylinder} > last_l) ? last_c : in_req.cylinder[CW-1:0];
  assign head_c = ({1'b0, head_start_r} > last_l) ? last_c : head_start_r[CW-1:0];
  // entries are clamped again on the way out (last may have moved mid batch)
  assign bot_c  = (bot_val > last_c) ? last_c : bot_val;
  assign top_c  = (top_val > last_c) ? last_c : top_val;

  assign in_req.ready = (state_r == ST_LOAD);
  assign in_acc       = in_req.valid && in_req.ready;
  assign can_load     = !out_valid_r || out_rec.ready;

  sds_row #(
    .N    (MAX_REQUESTS),
    .CW   (CW),
    .CNTW (CNTW),
    .IDXW (IDXW)
  ) u_row (
    .clk     (clk),
    .op      (row_op),
    .din     (req_c),
    .count   (cnt_r),
    .bot_val (bot_val),
    .top_val (top_val)
  );

  assign em_dist  = (em_from > em_to) ? em_from - em_to : em_to - em_from;
  assign seek_sum = {1'b0, seek_r} + (SEEK_W + 1)'(em_dist);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    lo_nxt     = lo_r;
    pos_nxt    = pos_r;
    drop_nxt   = drop_r;
    row_op     = CELL_HOLD;
    emit       = 1'b0;
    emit_total = 1'b0;
    em_from    = pos_r;
    em_to      = pos_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r != CNT_FULL) begin
            row_op  = CELL_INSERT;
            cnt_nxt = cnt_r + CNTW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_req.batch_end) begin
            state_nxt = ST_SKIP;
            lo_nxt    = '0;
          end
        end
      end
      ST_SKIP: begin
        if (lo_r != cnt_r && bot_c < head_c) begin
          row_op = CELL_ROTATE;
          lo_nxt = lo_r + CNTW'(1);
        end else begin
          state_nxt = ST_UP;
          pos_nxt   = head_c;
        end
      end
      ST_UP: begin
        if (cnt_r != lo_r) begin
          em_to = bot_c;
          if (can_load) begin
            emit    = 1'b1;
            row_op  = CELL_SHIFT;
            cnt_nxt = cnt_r - CNTW'(1);
            pos_nxt = bot_c;
          end
        end else begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        if (pos_r != last_c) begin
          em_to = last_c;
          if (can_load) begin
            emit      = 1'b1;
            pos_nxt   = last_c;
            state_nxt = ST_DOWN;
          end
        end else begin
          state_nxt = ST_DOWN;
        end
      end
      ST_DOWN: begin
        if (cnt_r != '0) begin
          em_to = top_c;
          if (can_load) begin
            emit    = 1'b1;
            cnt_nxt = cnt_r - CNTW'(1);
            pos_nxt = top_c;
          end
        end else begin
          state_nxt = ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        if (can_load) begin
          emit_total = 1'b1;
          drop_nxt   = 1'b0;
          state_nxt  = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    seek_nxt = seek_r;
    if (emit) begin
      seek_nxt = seek_sum[SEEK_W] ? {SEEK_W{1'b1}} : seek_sum[SEEK_W-1:0];
    end else if (emit_total) begin
      seek_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_cyl_r   <= DC_W'(200);
      head_start_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISK_CYL:   disk_cyl_r   <= cfg_data[DC_W-1:0];
        REG_HEAD_START: head_start_r <= cfg_data[CYL_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      lo_r        <= '0;
      seek_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lo_r    <= lo_nxt;
      seek_r  <= seek_nxt;
      drop_r  <= drop_nxt;
      if (can_load) begin
        out_valid_r <= emit || emit_total;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (emit) begin
      out_kind_r  <= KIND_MOVE;
      out_from_r  <= CYL_W'(em_from);
      out_to_r    <= CYL_W'(em_to);
      out_dist_r  <= CYL_W'(em_dist);
      out_total_r <= '0;
      out_ovf_r   <= drop_r;
      out_final_r <= 1'b0;
    end else if (emit_total) begin
      out_kind_r  <= KIND_TOTAL;
      out_from_r  <= '0;
      out_to_r    <= '0;
      out_dist_r  <= '0;
      out_total_r <= seek_r;
      out_ovf_r   <= drop_r;
      out_final_r <= 1'b1;
    end
  end

  assign out_rec.valid        = out_valid_r;
  assign out_rec.record_kind  = out_kind_r;
  assign out_rec.from_cyl     = out_from_r;
  assign out_rec.to_cyl       = out_to_r;
  assign out_rec.distance     = out_dist_r;
  assign out_rec.total_seek   = out_total_r;
  assign out_rec.overflowed   = out_ovf_r;
  assign out_rec.final_record = out_final_r;

  // row never holds more than its cells
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count beyond row size");

  // request into a full row must raise the drop flag
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cnt_r == CNT_FULL) |=> drop_r)
    else $error("dropped request not flagged");

  // total record leaves the batch state empty and presents the final record
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TOTAL && can_load) |=>
      (cnt_r == '0 && seek_r == '0 && !drop_r && out_valid_r && out_final_r))
    else $error("batch state not cleared after total record");

endmodule

// File: sim/scan_disk_schedule_unit_tb.sv
// Self-checking testbench for the SCAN disk scheduler: sweep prediction and record checks.
`timescale 1ns / 1ps

typedef struct packed {
  logic                         record_kind;
  logic [sds_pkg::CYL_W-1:0]    from_cyl;
  logic [sds_pkg::CYL_W-1:0]    to_cyl;
  logic [sds_pkg::CYL_W-1:0]    distance;
  logic [sds_pkg::SEEK_W-1:0]   total_seek;
  logic                         overflowed;
  logic                         final_record;
} seek_rec_t;

// Mirror of the sorted row; works out the sweep for each closed batch
class sweep_predictor;
  localparam int ROW_MAX = 16;

  logic [sds_pkg::DC_W-1:0]   n_cyls;
  logic [sds_pkg::CYL_W-1:0]  head_reg;
  logic [sds_pkg::CYL_W-1:0]  row [ROW_MAX+1];
  int                         count;
  logic [sds_pkg::SEEK_W-1:0] seek;
  logic                       dropped;
  seek_rec_t                  due[$];
  int errors, moves_seen, totals_seen, overflow_batches;

  function new();
    n_cyls = 200;
    head_reg = '0;
    count = 0;
    seek = '0;
    dropped = 1'b0;
    errors = 0;
    moves_seen = 0;
    totals_seen = 0;
    overflow_batches = 0;
  endfunction

  function void write_reg(logic [sds_pkg::CFG_IDX_W-1:0] idx,
                          logic [sds_pkg::CFG_DAT_W-1:0] data);
    if (idx == sds_pkg::REG_DISK_CYL) n_cyls = data;
    else if (idx == sds_pkg::REG_HEAD_START) head_reg = data[sds_pkg::CYL_W-1:0];
  endfunction

  function logic [sds_pkg::CYL_W-1:0] last_cyl();
    if (n_cyls == 0) return '0;
    if (n_cyls > 17'h10000) return 16'hFFFF;
    return 16'(n_cyls - 1);
  endfunction

  // equal values go after those already held
  function void place(logic [sds_pkg::CYL_W-1:0] v);
    int pos;
    pos = 0;
    while (pos < count && row[pos] <= v) pos++;
    for (int i = count; i > pos; i--) row[i] = row[i-1];
    row[pos] = v;
    count++;
  endfunction

  function void add_move(logic [sds_pkg::CYL_W-1:0] a, logic [sds_pkg::CYL_W-1:0] b);
    seek_rec_t r;
    logic [sds_pkg::CYL_W-1:0] d;
    int s;
    d = (a > b) ? a - b : b - a;
    s = int'(seek) + int'(d);
    seek = (s > 18'h3FFFF) ? 18'h3FFFF : s[sds_pkg::SEEK_W-1:0];
    r = '0;
    r.record_kind = sds_pkg::KIND_MOVE;
    r.from_cyl = a;
    r.to_cyl = b;
    r.distance = d;
    r.overflowed = dropped;
    due.push_back(r);
  endfunction

  function void take_request(logic [sds_pkg::CYL_W-1:0] cyl, logic last_of_batch);
    logic [sds_pkg::CYL_W-1:0] lim, hd, pos;
    seek_rec_t r;
    int h;
    lim = last_cyl();
    if (count < ROW_MAX) place((cyl > lim) ? lim : cyl);
    else dropped = 1'b1;
    if (!last_of_batch) return;
    // geometry may have shrunk since the entry went in
    for (int i = 0; i < count; i++) if (row[i] > lim) row[i] = lim;
    hd = (head_reg > lim) ? lim : head_reg;
    h = 0;
    while (h < count && row[h] < hd) h++;
    place(hd);
    for (int i = h; i + 1 < count; i++) add_move(row[i], row[i+1]);
    pos = row[count-1];
    if (pos != lim) begin
      add_move(pos, lim);
      pos = lim;
    end
    if (h > 0) begin
      add_move(pos, row[h-1]);
      for (int i = h - 1; i > 0; i--) add_move(row[i], row[i-1]);
    end
    r = '0;
    r.record_kind = sds_pkg::KIND_TOTAL;
    r.total_seek = seek;
    r.overflowed = dropped;
    r.final_record = 1'b1;
    due.push_back(r);
    if (dropped) overflow_batches++;
    count = 0;
    seek = '0;
    dropped = 1'b0;
  endfunction

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void match_record(seek_rec_t got);
    seek_rec_t want;
    if (due.size() == 0) begin
      $error("record with nothing outstanding: kind %0d from %0d to %0d",
             got.record_kind, got.from_cyl, got.to_cyl);
      errors++;
      return;
    end
    want = due.pop_front();
    if (want.record_kind == sds_pkg::KIND_TOTAL) totals_seen++;
    else moves_seen++;
    check_field("record_kind", want.record_kind, got.record_kind);
    check_field("from_cyl", want.from_cyl, got.from_cyl);
    check_field("to_cyl", want.to_cyl, got.to_cyl);
    check_field("distance", want.distance, got.distance);
    check_field("total_seek", want.total_seek, got.total_seek);
    check_field("overflowed", want.overflowed, got.overflowed);
    check_field("final_record", want.final_record, got.final_record);
  endfunction
endclass

module scan_disk_schedule_unit_tb;
  import sds_pkg::*;

  // index outside the register map; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(9);
  // quiet time after every record has drained, with margin
  localparam int SETTLE_CYCLES   = 60;
  localparam int RANDOM_REQUESTS = 250;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  sds_req_if in_req ();
  sds_rec_if out_rec ();

  scan_disk_schedule_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rec   (out_rec),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sweep_predictor sched = new();

  bit calm;              // both sides flat out while set
  int requests_sent;
  int batches_sent;
  int geometry_changes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // One request: random idle first, then hold it until the block takes it.
  task automatic send_request(input logic [CYL_W-1:0] cyl, input logic last_of_batch);
    while (!calm && $urandom_range(99) < 35) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.cylinder  <= cyl;
    in_req.batch_end <= last_of_batch;
    do @(posedge clk); while (!in_req.ready);
    sched.take_request(cyl, last_of_batch);
    requests_sent++;
    if (last_of_batch) batches_sent++;
  endtask

  // Drop valid, let every record drain, then give the block time to go quiet.
  task automatic settle();
    in_req.valid <= 1'b0;
    while (sched.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, plus a write to an unmapped index that must do nothing.
  task automatic set_geometry(input logic [DC_W-1:0] cyls, input logic [CYL_W-1:0] head);
    logic [CFG_DAT_W-1:0] junk;
    junk = CFG_DAT_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DISK_CYL;
    cfg_data  <= cyls;
    @(posedge clk);
    sched.write_reg(REG_DISK_CYL, cyls);
    cfg_index <= REG_HEAD_START;
    cfg_data  <= CFG_DAT_W'(head);
    @(posedge clk);
    sched.write_reg(REG_HEAD_START, CFG_DAT_W'(head));
    cfg_index <= REG_SPARE;
    cfg_data  <= junk;
    @(posedge clk);
    sched.write_reg(REG_SPARE, junk);
    cfg_we <= 1'b0;
    geometry_changes++;
  endtask

  // Mostly on the disk, with extremes, head hits and raw 16-bit noise.
  function automatic logic [CYL_W-1:0] pick_cylinder();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return sched.head_reg;
      3:       return CYL_W'($urandom);
      default: return CYL_W'($urandom_range(int'(sched.last_cyl())));
    endcase
  endfunction

  task automatic random_batch(input int len);
    for (int i = 0; i < len; i++) send_request(pick_cylinder(), i == len - 1);
  endtask

  task automatic random_geometry();
    logic [DC_W-1:0]  cyls;
    logic [CYL_W-1:0] head;
    case ($urandom_range(7))
      0:       cyls = '0;
      1:       cyls = 17'h10000;
      2:       cyls = 17'h1FFFF;
      3, 4:    cyls = DC_W'($urandom_range(300, 1));
      default: cyls = DC_W'($urandom);
    endcase
    // head usually on the disk, sometimes past the end
    if ($urandom_range(1) == 0 && cyls != 0)
      head = CYL_W'($urandom_range(int'(cyls) - 1));
    else
      head = CYL_W'($urandom);
    set_geometry(cyls, head);
  endtask

  // Result side: check on accept, then decide ready for the next cycle.
  initial begin
    seek_rec_t got;
    out_rec.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_rec.valid && out_rec.ready) begin
        got.record_kind  = out_rec.record_kind;
        got.from_cyl     = out_rec.from_cyl;
        got.to_cyl       = out_rec.to_cyl;
        got.distance     = out_rec.distance;
        got.total_seek   = out_rec.total_seek;
        got.overflowed   = out_rec.overflowed;
        got.final_record = out_rec.final_record;
        sched.match_record(got);
      end
      out_rec.ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  initial begin
    int rand_batches;
    int len;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_DISK_CYL;
    cfg_data         <= '0;
    in_req.valid     <= 1'b0;
    in_req.cylinder  <= '0;
    in_req.batch_end <= 1'b0;
    calm             = 1'b0;
    requests_sent    = 0;
    batches_sent     = 0;
    geometry_changes = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // reset geometry: 200 cylinders, head at 0
    // lone request sitting on the head: zero-distance move, then run to the end
    send_request(16'd0, 1'b1);
    // at the end, past the end (clamped), duplicates, a mid value
    send_request(16'd199, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd50, 1'b0);
    send_request(16'd50, 1'b0);
    send_request(16'd120, 1'b1);

    // head mid-disk: requests both sides, one on the head, one on the last cylinder
    settle();
    set_geometry(17'd1000, 16'd500);
    send_request(16'd10, 1'b0);
    send_request(16'd999, 1'b0);
    send_request(16'd500, 1'b0);
    send_request(16'd700, 1'b0);
    send_request(16'd0, 1'b1);

    // zero cylinders: everything, head included, collapses onto cylinder 0
    settle();
    set_geometry(17'd0, 16'hFFFF);
    send_request(16'hAAAA, 1'b0);
    send_request(16'h5555, 1'b1);

    // more cylinders than the field holds: last cylinder saturates
    settle();
    set_geometry(17'h1FFFF, 16'h8000);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b0);
    send_request(16'h7FFF, 1'b1);

    // disk shrinks while a batch is half loaded; held entries get re-clamped
    settle();
    set_geometry(17'h10000, 16'd100);
    send_request(16'd60000, 1'b0);
    send_request(16'd30000, 1'b0);
    settle();
    set_geometry(17'd40000, 16'd20000);
    send_request(16'd5, 1'b1);

    // --- random ---
    settle();
    random_geometry();
    // first one overfills the row so the drop path is hit early
    random_batch(20);
    rand_batches = 1;
    while (requests_sent < RANDOM_REQUESTS + 19) begin
      if (rand_batches % 4 == 3) begin
        settle();
        random_geometry();
      end
      // a stretch in the middle with no gaps on either side
      calm = (requests_sent > 110 && requests_sent < 170);
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
      random_batch(len);
      rand_batches++;
    end
    calm = 1'b0;

    settle();
    $display("Sent %0d requests in %0d batches over %0d disk geometries",
             requests_sent, batches_sent, geometry_changes);
    $display("Checked %0d move and %0d total records; %0d batches dropped requests",
             sched.moves_seen, sched.totals_seen, sched.overflow_batches);
    if (sched.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: scan_disk_schedule_unit.f
hdl/sds_pkg.sv
hdl/sds_req_if.sv
hdl/sds_rec_if.sv
hdl/sds_cell.sv
hdl/sds_row.sv
hdl/scan_disk_schedule_unit.sv
sim/scan_disk_schedule_unit_tb.sv
